[design/deque_with_reverse_defines.svh]
// Assertion macros for the deque_with_reverse block.
`ifndef DEQUE_WITH_REVERSE_DEFINES_SVH
`define DEQUE_WITH_REVERSE_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked property check, disabled while reset is asserted.
`define DWR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true.
`define DWR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `DWR_ASSERT(lbl, clk, rst_n, !(cond), msg)

`else

`define DWR_ASSERT(lbl, clk, rst_n, prop, msg)
`define DWR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[design/dwr_pkg.sv]
// Types and codes shared by the deque_with_reverse block.
`default_nettype none

package dwr_pkg;

  localparam int unsigned DepthDefault = 64;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_LIST       = 3'd4,
    OP_REVERSE    = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_LISTED = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_FULL   = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_LIST = 1'b1
  } state_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] data_value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] item_value;
    logic [1:0]         status;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

[design/deque_with_reverse.sv]
// A push gives no result (busy stays low, one push per cycle while not listing); a refused push
// or an operation on an empty queue gives its status result in the cycle after acceptance.
// Listing (pop, list, reverse) of n elements: results follow the listing state through the
// store read register, one per cycle; busy is high for n reads, set by the single ring store read port.
// Reset (rst_ni low, asynchronous) clears front position, count, reverse flag and the
// sequencer; the ring store is not cleared. Results cannot be stalled by the receiver.
`default_nettype none
`include "deque_with_reverse_defines.svh"

module deque_with_reverse #(
  parameter int unsigned DEPTH = dwr_pkg::DepthDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire dwr_pkg::cmd_t cmd_i,
  output logic               res_valid_o,
  output dwr_pkg::res_t      res_o
);

  localparam int unsigned IDXW = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);
  localparam logic [IDXW-1:0] LastIdx  = IDXW'(DEPTH - 1);
  localparam logic [CNTW-1:0] DepthCnt = CNTW'(DEPTH);
  localparam logic [CNTW-1:0] OneCnt   = CNTW'(1);

  // ring position helpers
  function automatic logic [IDXW-1:0] wrap_add(logic [IDXW-1:0] a, logic [CNTW-1:0] b);
    logic [CNTW:0] s;
    s = (CNTW+1)'(a) + (CNTW+1)'(b);
    if (s >= (CNTW+1)'(DEPTH)) s = s - (CNTW+1)'(DEPTH);
    return s[IDXW-1:0];
  endfunction

  function automatic logic [IDXW-1:0] wrap_inc(logic [IDXW-1:0] a);
    return (a == LastIdx) ? '0 : a + IDXW'(1);
  endfunction

  function automatic logic [IDXW-1:0] wrap_dec(logic [IDXW-1:0] a);
    return (a == '0) ? LastIdx : a - IDXW'(1);
  endfunction

  // queue state
  dwr_pkg::state_e state_q, state_d;
  logic [IDXW-1:0] front_q, front_d;
  logic [CNTW-1:0] count_q, count_d;
  logic            rev_q, rev_d;

  // listing walk: physical read pointer and elements still to read
  logic [IDXW-1:0] ptr_q, ptr_d;
  logic [CNTW-1:0] rem_q, rem_d;

  // result registers; item value comes from the store read register
  logic            ov_q, ov_d;
  dwr_pkg::status_e ost_q, ost_d;
  logic            olast_q, olast_d;
  logic            omem_q, omem_d;

  // ring store port controls
  logic            mem_we;
  logic [IDXW-1:0] mem_waddr;
  logic [31:0]     mem_wdata;
  logic            mem_re;
  logic [31:0]     mem_rdata_q;
  logic [31:0]     mem_q [DEPTH];

  logic accept;
  logic at_start;
  logic list_go;

  assign busy   = (state_q == dwr_pkg::S_LIST);
  assign accept = start && !busy;

  always_comb begin
    state_d   = state_q;
    front_d   = front_q;
    count_d   = count_q;
    rev_d     = rev_q;
    ptr_d     = ptr_q;
    rem_d     = rem_q;
    ov_d      = 1'b0;
    ost_d     = dwr_pkg::STAT_LISTED;
    olast_d   = 1'b0;
    omem_d    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = front_q;
    mem_wdata = cmd_i.data_value;
    mem_re    = 1'b0;
    at_start  = 1'b0;
    list_go   = 1'b0;

    unique case (state_q)
      dwr_pkg::S_IDLE: begin
        if (accept) begin
          unique case (cmd_i.opcode)
            dwr_pkg::OP_PUSH_FRONT, dwr_pkg::OP_PUSH_BACK: begin
              if (count_q == DepthCnt) begin
                ov_d    = 1'b1;
                ost_d   = dwr_pkg::STAT_FULL;
                olast_d = 1'b1;
              end else begin
                // push front lands at the physical start unless reversed
                at_start = (cmd_i.opcode == dwr_pkg::OP_PUSH_FRONT) ^ rev_q;
                mem_we   = 1'b1;
                if (at_start) begin
                  front_d   = wrap_dec(front_q);
                  mem_waddr = wrap_dec(front_q);
                end else begin
                  mem_waddr = wrap_add(front_q, count_q);
                end
                count_d = count_q + OneCnt;
              end
            end
            dwr_pkg::OP_POP_FRONT, dwr_pkg::OP_POP_BACK: begin
              if (count_q == '0) begin
                ov_d    = 1'b1;
                ost_d   = dwr_pkg::STAT_EMPTY;
                olast_d = 1'b1;
              end else begin
                at_start = (cmd_i.opcode == dwr_pkg::OP_POP_FRONT) ^ rev_q;
                if (at_start) front_d = wrap_inc(front_q);
                count_d = count_q - OneCnt;
                list_go = 1'b1;
              end
            end
            dwr_pkg::OP_LIST: begin
              list_go = 1'b1;
            end
            dwr_pkg::OP_REVERSE: begin
              if (count_q == '0) begin
                ov_d    = 1'b1;
                ost_d   = dwr_pkg::STAT_EMPTY;
                olast_d = 1'b1;
              end else begin
                rev_d   = ~rev_q;
                list_go = 1'b1;
              end
            end
            default: begin
              // unused codes: no result, no state change
            end
          endcase

          if (list_go) begin
            if (count_d == '0) begin
              // nothing left to list: single empty result
              ov_d    = 1'b1;
              ost_d   = dwr_pkg::STAT_EMPTY;
              olast_d = 1'b1;
            end else begin
              state_d = dwr_pkg::S_LIST;
              rem_d   = count_d;
              ptr_d   = rev_d ? wrap_add(front_d, count_d - OneCnt) : front_d;
            end
          end
        end
      end
      dwr_pkg::S_LIST: begin
        // one read per cycle; the result shows up with the read data next cycle
        mem_re  = 1'b1;
        ov_d    = 1'b1;
        omem_d  = 1'b1;
        olast_d = (rem_q == OneCnt);
        rem_d   = rem_q - OneCnt;
        ptr_d   = rev_q ? wrap_dec(ptr_q) : wrap_inc(ptr_q);
        if (rem_q == OneCnt) state_d = dwr_pkg::S_IDLE;
      end
      default: begin
        state_d = dwr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dwr_pkg::S_IDLE;
      front_q <= '0;
      count_q <= '0;
      rev_q   <= 1'b0;
      ptr_q   <= '0;
      rem_q   <= '0;
      ov_q    <= 1'b0;
      ost_q   <= dwr_pkg::STAT_LISTED;
      olast_q <= 1'b0;
      omem_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      rev_q   <= rev_d;
      ptr_q   <= ptr_d;
      rem_q   <= rem_d;
      ov_q    <= ov_d;
      ost_q   <= ost_d;
      olast_q <= olast_d;
      omem_q  <= omem_d;
    end
  end

  // Ring store. Writes happen only in idle, reads only while listing,
  // so the sequencer itself keeps the two ports off the same cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_q <= mem_q[ptr_q];
  end

  assign res_valid_o      = ov_q;
  assign res_o.item_value = omem_q ? mem_rdata_q : 32'sd0;
  assign res_o.status     = ost_q;
  assign res_o.last       = olast_q;

  // checks
  `DWR_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > DepthCnt, "count above depth")
  `DWR_ASSERT_NEVER(a_no_write_in_list, clk_i, rst_ni, busy && mem_we, "store write while listing")
  `DWR_ASSERT(a_listed_from_walk, clk_i, rst_ni, (ov_q && ost_q == dwr_pkg::STAT_LISTED) |-> $past(state_q == dwr_pkg::S_LIST), "listed result without a read")
  `DWR_ASSERT(a_push_counts, clk_i, rst_ni, (accept && count_q != DepthCnt && (cmd_i.opcode == dwr_pkg::OP_PUSH_FRONT || cmd_i.opcode == dwr_pkg::OP_PUSH_BACK)) |=> (count_q == $past(count_q) + OneCnt), "push did not grow count")

endmodule

`default_nettype wire

[verif/tb_deque_with_reverse.sv]
// Self-checking testbench for the deque_with_reverse block: random and directed deque operations.
`default_nettype none

module tb_deque_with_reverse;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth      = dwr_pkg::DepthDefault;
  localparam int ClkPeriod  = 10;
  localparam int ResetCycles = 9;
  localparam int ItemTarget = 230;
  // A listing of a full store is Depth results after the listing state and store read register.
  localparam int DrainCycles = Depth + 8;
  // Worst run: every item gets a full listing and the longest sender gap; the timeout allows many times that.
  localparam int TimeoutNs  = 5_000_000;
  localparam int MaxReports = 10;

  // Opcodes outside the enum; the block must ignore them.
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_ANY} mix_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  dwr_pkg::cmd_t cmd_drv = '0;
  logic busy;
  logic res_valid_o;
  dwr_pkg::res_t res_o;

  deque_with_reverse #(
    .DEPTH(Depth)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_drv),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow deque: ring store, front slot, element count, direction flag.
  // ---------------------------------------------------------------------------
  logic signed [31:0] ring [Depth];
  int   front_pos  = 0;
  int   elem_count = 0;
  logic rev_flag   = 1'b0;

  // Results still owed by the block, oldest first.
  dwr_pkg::res_t listing_q [$];
  // Transactions not yet offered to the block.
  dwr_pkg::cmd_t cmd_backlog [$];

  int accepted_cnt = 0;
  int total_cmds   = 0;
  int mismatches   = 0;

  function automatic void post_status(input dwr_pkg::status_e code);
    dwr_pkg::res_t r;
    r        = '0;
    r.status = code;
    r.last   = 1'b1;
    listing_q.push_back(r);
  endfunction

  // Contents from logical front to logical back; an empty deque lists as one
  // empty-status result.
  function automatic void post_listing();
    dwr_pkg::res_t r;
    int   slot;
    if (elem_count == 0) begin
      post_status(dwr_pkg::STAT_EMPTY);
      return;
    end
    for (int i = 0; i < elem_count; i++) begin
      slot = rev_flag ? (front_pos + elem_count - 1 - i) % Depth
                      : (front_pos + i) % Depth;
      r            = '0;
      r.item_value = ring[slot];
      r.status     = dwr_pkg::STAT_LISTED;
      r.last       = (i == elem_count - 1);
      listing_q.push_back(r);
    end
  endfunction

  // Update the shadow deque for one accepted transaction and queue its results.
  function automatic void apply_deque_op(input dwr_pkg::cmd_t c);
    logic at_phys_start;
    case (c.opcode)
      dwr_pkg::OP_PUSH_FRONT, dwr_pkg::OP_PUSH_BACK: begin
        if (elem_count >= Depth) begin
          post_status(dwr_pkg::STAT_FULL);
        end else begin
          // reversed: logical front is the physical back
          at_phys_start = (c.opcode == dwr_pkg::OP_PUSH_FRONT) ^ rev_flag;
          if (at_phys_start) begin
            front_pos       = (front_pos + Depth - 1) % Depth;
            ring[front_pos] = c.data_value;
          end else begin
            ring[(front_pos + elem_count) % Depth] = c.data_value;
          end
          elem_count++;
        end
      end
      dwr_pkg::OP_POP_FRONT, dwr_pkg::OP_POP_BACK: begin
        if (elem_count == 0) begin
          post_status(dwr_pkg::STAT_EMPTY);
        end else begin
          at_phys_start = (c.opcode == dwr_pkg::OP_POP_FRONT) ^ rev_flag;
          if (at_phys_start) front_pos = (front_pos + 1) % Depth;
          elem_count--;
          post_listing();
        end
      end
      dwr_pkg::OP_LIST: post_listing();
      dwr_pkg::OP_REVERSE: begin
        // empty deque: no toggle, just the empty status
        if (elem_count == 0) begin
          post_status(dwr_pkg::STAT_EMPTY);
        end else begin
          rev_flag = ~rev_flag;
          post_listing();
        end
      end
      default: ; // spare opcodes: no effect, no result
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  task automatic add_cmd(input logic [2:0] op, input logic signed [31:0] val);
    dwr_pkg::cmd_t c;
    c.opcode     = op;
    c.data_value = val;
    cmd_backlog.push_back(c);
  endtask

  function automatic logic signed [31:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 32'sh7fff_ffff;
    if (roll == 1) return 32'sh8000_0000;
    return $urandom;
  endfunction

  // Fill runs are push-heavy to reach a full store, drain runs pop-heavy to
  // walk back to empty; the rest is an even mix including spare opcodes.
  function automatic logic [2:0] pick_op(input mix_e mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      MIX_FILL: begin
        if (roll < 45) return dwr_pkg::OP_PUSH_FRONT;
        if (roll < 90) return dwr_pkg::OP_PUSH_BACK;
        if (roll < 95) return dwr_pkg::OP_LIST;
        return dwr_pkg::OP_REVERSE;
      end
      MIX_DRAIN: begin
        if (roll < 40) return dwr_pkg::OP_POP_FRONT;
        if (roll < 80) return dwr_pkg::OP_POP_BACK;
        if (roll < 90) return dwr_pkg::OP_REVERSE;
        if (roll < 95) return dwr_pkg::OP_PUSH_BACK;
        return dwr_pkg::OP_LIST;
      end
      default: return 3'($urandom_range(0, 7));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers backlog transactions in bursts separated by random gaps.
  // A transaction is taken at an edge where start is high and busy is low.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    logic nxt_start;
    dwr_pkg::cmd_t nxt_cmd;
    nxt_start = start;
    nxt_cmd   = cmd_drv;
    if (rst_ni) begin
      if (start && !busy) begin
        apply_deque_op(cmd_drv);
        accepted_cnt++;
        nxt_start = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // about a third of the bursts run straight into the next one
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end
      end
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() > 0) begin
          nxt_cmd   = cmd_backlog.pop_front();
          nxt_start = 1'b1;
        end
      end
    end
    // one assignment per edge keeps start steady across back-to-back items
    start   <= nxt_start;
    cmd_drv <= nxt_cmd;
  end

  // ---------------------------------------------------------------------------
  // Monitor: each strobed result is checked against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    dwr_pkg::res_t want;
    if (rst_ni && res_valid_o) begin
      if (listing_q.size() == 0) begin
        if (mismatches < MaxReports)
          $display("%0t: unexpected result value %0d status %0d last %0b",
                   $realtime, res_o.item_value, res_o.status, res_o.last);
        mismatches++;
      end else begin
        want = listing_q.pop_front();
        if (res_o.item_value !== want.item_value || res_o.status !== want.status ||
            res_o.last !== want.last) begin
          if (mismatches < MaxReports)
            $display("%0t: mismatch exp value %0d status %0d last %0b, got %0d %0d %0b",
                     $realtime, want.item_value, want.status, want.last,
                     res_o.item_value, res_o.status, res_o.last);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: build the backlog, release reset, wait for the drain.
  // ---------------------------------------------------------------------------
  initial begin
    mix_e mode;
    int   seg_len;
    bit   first_seg;

    // Directed: empty-queue status on every reading op, extremes of data,
    // reverse with data, spare opcodes, and a pop that leaves the deque empty.
    add_cmd(dwr_pkg::OP_LIST,       32'sd0);
    add_cmd(dwr_pkg::OP_POP_FRONT,  32'sd0);
    add_cmd(dwr_pkg::OP_POP_BACK,   32'sd0);
    add_cmd(dwr_pkg::OP_REVERSE,    32'sd0);
    add_cmd(dwr_pkg::OP_PUSH_FRONT, 32'sh7fff_ffff);
    add_cmd(dwr_pkg::OP_PUSH_BACK,  32'sh8000_0000);
    add_cmd(dwr_pkg::OP_PUSH_FRONT, 32'sd0);
    add_cmd(dwr_pkg::OP_PUSH_BACK,  -32'sd1);
    add_cmd(dwr_pkg::OP_LIST,       32'sd0);
    add_cmd(dwr_pkg::OP_REVERSE,    32'sd0);
    add_cmd(dwr_pkg::OP_PUSH_FRONT, 32'sd1);
    add_cmd(dwr_pkg::OP_PUSH_BACK,  32'sd2);
    add_cmd(dwr_pkg::OP_LIST,       32'sd0);
    add_cmd(dwr_pkg::OP_POP_FRONT,  32'sd0);
    add_cmd(dwr_pkg::OP_POP_BACK,   32'sd0);
    add_cmd(OpSpare6,               32'sh5555_aaaa);
    add_cmd(OpSpare7,               32'sh1234_5678);
    add_cmd(dwr_pkg::OP_REVERSE,    32'sd0);
    add_cmd(dwr_pkg::OP_POP_BACK,   32'sd0);
    add_cmd(dwr_pkg::OP_POP_FRONT,  32'sd0);
    add_cmd(dwr_pkg::OP_POP_FRONT,  32'sd0);
    add_cmd(dwr_pkg::OP_POP_BACK,   32'sd0);  // last element goes, listing is empty
    add_cmd(dwr_pkg::OP_POP_FRONT,  32'sd0);

    // Random: the first run fills past capacity so refused pushes show up.
    first_seg = 1'b1;
    while (cmd_backlog.size() < ItemTarget) begin
      mode      = first_seg ? MIX_FILL : mix_e'($urandom_range(0, 2));
      seg_len   = first_seg ? 90 : $urandom_range(15, 60);
      first_seg = 1'b0;
      // last run is trimmed so the total lands on the target
      if (seg_len > ItemTarget - cmd_backlog.size())
        seg_len = ItemTarget - cmd_backlog.size();
      repeat (seg_len) add_cmd(pick_op(mode), pick_value());
    end
    total_cmds = cmd_backlog.size();

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // negedge sampling keeps these checks clear of the driver's edge
    while (accepted_cnt < total_cmds) @(negedge clk_i);
    while (listing_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (mismatches == 0 && listing_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Watchdog in case the block hangs or stops answering.
  initial begin
    #(TimeoutNs);
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+design
design/dwr_pkg.sv
design/deque_with_reverse.sv
verif/tb_deque_with_reverse.sv
